### src/ndc_rpc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ndc_rpc_pkg
// Shared types, register indexes and mapping modes for the raster placement
// and clip core.
// ----------------------------------------------------------------------------
package ndc_rpc_pkg;

    localparam int COORD_BITS_DEF = 16;
    localparam int NORM_BITS      = 15;
    localparam int SIZE_BITS      = 12;
    localparam int REG_BITS       = 16;
    localparam int QUOT_BITS      = NORM_BITS + 10;   // (n << 10) / d with d >= 1
    localparam int CFG_IDX_BITS   = 3;

    typedef enum logic [2:0] {
        MODE_WINDOW    = 3'd0,
        MODE_SQ_FIT_X  = 3'd1,
        MODE_SQ_FIT_Y  = 3'd2,
        MODE_NSQ_FIT_X = 3'd3,
        MODE_NSQ_FIT_Y = 3'd4,
        MODE_DIVIDE    = 3'd5
    } t_map_mode;

    localparam logic [CFG_IDX_BITS-1:0] REG_MAP_MODE = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_X_OFFSET = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_Y_OFFSET = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_Y_TOP    = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_DIVISOR  = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] REG_X_GAIN   = 3'd5;
    localparam logic [CFG_IDX_BITS-1:0] REG_Y_GAIN   = 3'd6;

    // configuration as seen by the mapping units
    typedef struct packed {
        logic [2:0]          mode;
        logic signed [15:0]  x_offset;
        logic signed [15:0]  y_offset;
        logic signed [15:0]  y_top;
        logic [15:0]         divisor;
        logic [15:0]         x_gain;
        logic [15:0]         y_gain;
    } t_cfg;

endpackage

### src/ndc_rpc_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ndc_rpc_div
// Pipelined restoring divider: (n << 10) / d, one quotient bit per stage.
// ----------------------------------------------------------------------------
module ndc_rpc_div (
    input  logic                                  i_clk,
    input  logic                                  i_en,
    input  logic [ndc_rpc_pkg::NORM_BITS-1:0]     i_num,
    input  logic [15:0]                           i_den,
    output logic [ndc_rpc_pkg::QUOT_BITS-1:0]     o_quot
);
    localparam int QB = ndc_rpc_pkg::QUOT_BITS;

    // stage s holds remainder, remaining dividend bits, quotient so far
    logic [16:0]   r_rem [QB+1];
    logic [QB-1:0] r_dvd [QB+1];
    logic [QB-1:0] r_quo [QB+1];
    logic [15:0]   r_den [QB+1];

    always_comb begin
        r_rem[0] = '0;
        r_dvd[0] = {i_num, 10'd0};
        r_quo[0] = '0;
        r_den[0] = (i_den == 16'd0) ? 16'd1 : i_den;
    end

    for (genvar s = 0; s < QB; s++) begin : g_stage
        logic [16:0] w_sh;
        logic [17:0] w_diff;
        assign w_sh   = {r_rem[s][15:0], r_dvd[s][QB-1]};
        assign w_diff = {1'b0, w_sh} - {2'b00, r_den[s]};
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[s+1] <= w_diff[17] ? w_sh : w_diff[16:0];
                r_quo[s+1] <= {r_quo[s][QB-2:0], ~w_diff[17]};
                r_dvd[s+1] <= {r_dvd[s][QB-2:0], 1'b0};
                r_den[s+1] <= r_den[s];
            end
        end
    end

    assign o_quot = r_quo[QB];
endmodule

### src/ndc_rpc_map.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ndc_rpc_map
// Maps one normalized point to saturated device coordinates. Latency is
// matched on every mode (divider sets the depth).
// ----------------------------------------------------------------------------
module ndc_rpc_map #(
    parameter int COORD_BITS = ndc_rpc_pkg::COORD_BITS_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_en,
    input  ndc_rpc_pkg::t_cfg                     i_cfg,
    input  logic [ndc_rpc_pkg::NORM_BITS-1:0]     i_nx,
    input  logic [ndc_rpc_pkg::NORM_BITS-1:0]     i_ny,
    output logic signed [COORD_BITS-1:0]          o_dx,
    output logic signed [COORD_BITS-1:0]          o_dy
);
    localparam int NB  = ndc_rpc_pkg::NORM_BITS;
    localparam int QB  = ndc_rpc_pkg::QUOT_BITS;
    localparam int WB  = 36;     // wide enough for every pre-saturation value
    localparam int LAT = QB + 1;
    localparam logic signed [WB-1:0] HI = WB'((64'sd1 <<< (COORD_BITS-1)) - 1);
    localparam logic signed [WB-1:0] LO = -HI - WB'(1);

    // stage 0: products and fits
    logic [30:0]  r_px, r_py;
    logic [15:0]  r_fx, r_fy;
    logic [2:0]   r_mode;
    logic [QB-1:0] w_qx, w_qy;

    logic [NB:0] w_nsx, w_nsy;
    always_comb begin
        case (i_cfg.mode)
            ndc_rpc_pkg::MODE_NSQ_FIT_X: begin
                w_nsx = {1'b0, i_nx} + (NB+1)'(i_nx >> 3);
                w_nsy = {1'b0, i_ny} + (NB+1)'(i_ny >> 3);
            end
            ndc_rpc_pkg::MODE_NSQ_FIT_Y: begin
                w_nsx = {1'b0, i_nx} - (NB+1)'(i_nx >> 3);
                w_nsy = {1'b0, i_ny} - (NB+1)'(i_ny >> 3);
            end
            default: begin
                w_nsx = {1'b0, i_nx};
                w_nsy = {1'b0, i_ny};
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_px   <= 31'(i_nx) * 31'(i_cfg.x_gain);
            r_py   <= 31'(i_ny) * 31'(i_cfg.y_gain);
            r_fx   <= 16'(w_nsx >> 5);
            r_fy   <= 16'(w_nsy >> 5);
            r_mode <= i_cfg.mode;
        end
    end

    ndc_rpc_div u_div_x (.i_clk(i_clk), .i_en(i_en), .i_num(i_nx),
                         .i_den(i_cfg.divisor), .o_quot(w_qx));
    ndc_rpc_div u_div_y (.i_clk(i_clk), .i_en(i_en), .i_num(i_ny),
                         .i_den(i_cfg.divisor), .o_quot(w_qy));

    // delay line to line up with the divider
    logic [15:0] r_sx [QB-1];
    logic [15:0] r_sy [QB-1];
    logic [2:0]  r_md [QB-1];
    logic [15:0] w_sx, w_sy;
    always_comb begin
        case (r_mode)
            ndc_rpc_pkg::MODE_WINDOW: begin
                w_sx = 16'(r_px >> 15);
                w_sy = 16'(r_py >> 15);
            end
            default: begin
                w_sx = r_fx;
                w_sy = r_fy;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sx[0] <= w_sx;
            r_sy[0] <= w_sy;
            r_md[0] <= r_mode;
            for (int k = 1; k < QB-1; k++) begin
                r_sx[k] <= r_sx[k-1];
                r_sy[k] <= r_sy[k-1];
                r_md[k] <= r_md[k-1];
            end
        end
    end

    // final stage: pick, offset, flip, saturate
    logic signed [WB-1:0] w_vx, w_vy, w_rx, w_ry;
    logic [2:0] w_md;
    assign w_md = r_md[QB-2];
    always_comb begin
        case (w_md)
            ndc_rpc_pkg::MODE_WINDOW, ndc_rpc_pkg::MODE_SQ_FIT_X,
            ndc_rpc_pkg::MODE_SQ_FIT_Y, ndc_rpc_pkg::MODE_NSQ_FIT_X,
            ndc_rpc_pkg::MODE_NSQ_FIT_Y: begin
                w_vx = WB'(r_sx[QB-2]);
                w_vy = WB'(r_sy[QB-2]);
            end
            default: begin
                w_vx = WB'(w_qx);
                w_vy = WB'(w_qy);
            end
        endcase
        case (w_md)
            ndc_rpc_pkg::MODE_SQ_FIT_X, ndc_rpc_pkg::MODE_NSQ_FIT_X: begin
                w_rx = w_vx;
                w_ry = WB'(i_cfg.y_top) - (w_vy + WB'(i_cfg.y_offset));
            end
            default: begin
                w_rx = w_vx + WB'(i_cfg.x_offset);
                w_ry = WB'(i_cfg.y_top) - w_vy;
            end
        endcase
    end

    logic signed [COORD_BITS-1:0] r_dx, r_dy;
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dx <= (w_rx > HI) ? COORD_BITS'(HI) : (w_rx < LO) ? COORD_BITS'(LO)
                                                               : COORD_BITS'(w_rx);
            r_dy <= (w_ry > HI) ? COORD_BITS'(HI) : (w_ry < LO) ? COORD_BITS'(LO)
                                                               : COORD_BITS'(w_ry);
        end
    end

    assign o_dx = r_dx;
    assign o_dy = r_dy;
endmodule

### src/ndc_rpc_clip.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ndc_rpc_clip
// Two-stage rectangle clip of the raster against the viewport.
// ----------------------------------------------------------------------------
module ndc_rpc_clip #(
    parameter int COORD_BITS = ndc_rpc_pkg::COORD_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_en,
    input  logic signed [COORD_BITS-1:0]      i_ax, i_ay, i_left, i_bottom,
    input  logic signed [COORD_BITS-1:0]      i_right, i_top,
    input  logic [ndc_rpc_pkg::SIZE_BITS-1:0] i_w, i_h,
    output logic [15:0]                       o_dx, o_dy,
    output logic [ndc_rpc_pkg::SIZE_BITS-1:0] o_cw, o_ch, o_sx, o_sy,
    output logic                              o_vis
);
    localparam int EB = COORD_BITS + 3;
    localparam int SB = ndc_rpc_pkg::SIZE_BITS;

    // stage A: left and top edges
    logic signed [EB-1:0] w_x, w_y, w_xs, w_ys, w_w, w_h;
    always_comb begin
        w_x  = EB'(i_ax);
        w_y  = EB'(i_ay) - EB'({1'b0, i_h}) + EB'(1);
        w_w  = EB'({1'b0, i_w});
        w_h  = EB'({1'b0, i_h});
        w_xs = '0;
        w_ys = '0;
        if (w_x < EB'(i_left)) begin
            w_xs = EB'(i_left) - w_x;
            w_w  = w_w - w_xs;
            w_x  = EB'(i_left);
        end
        if (w_y < EB'(i_top)) begin
            w_ys = EB'(i_top) - w_y;
            w_h  = w_h - w_ys;
            w_y  = EB'(i_top);
        end
    end

    logic signed [EB-1:0] r_x, r_y, r_w, r_h, r_xs, r_ys;
    logic signed [COORD_BITS-1:0] r_r, r_b;
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x <= w_x;  r_y <= w_y;  r_w <= w_w;  r_h <= w_h;
            r_xs <= w_xs; r_ys <= w_ys; r_r <= i_right; r_b <= i_bottom;
        end
    end

    // stage B: right and bottom edges
    logic signed [EB-1:0] w_cw, w_ch;
    logic w_vis;
    always_comb begin
        w_cw = r_w;
        w_ch = r_h;
        if (r_x + r_w - EB'(1) > EB'(r_r)) w_cw = EB'(r_r) - r_x + EB'(1);
        if (r_y + r_h - EB'(1) > EB'(r_b)) w_ch = EB'(r_b) - r_y + EB'(1);
        w_vis = (w_cw > 0) && (w_ch > 0);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_vis <= w_vis;
            o_dx  <= w_vis ? 16'(r_x)  : 16'd0;
            o_dy  <= w_vis ? 16'(r_y)  : 16'd0;
            o_cw  <= w_vis ? SB'(w_cw) : '0;
            o_ch  <= w_vis ? SB'(w_ch) : '0;
            o_sx  <= w_vis ? SB'(r_xs) : '0;
            o_sy  <= w_vis ? SB'(r_ys) : '0;
        end
    end
endmodule

### src/ndc_raster_place_and_clip_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ndc_raster_place_and_clip_core
// Viewport mapping of anchor and corners, then clip of the raster rectangle.
//
//  channel  dir  payload
//  s_axis   in   tdata: anchor_x..upright_y (6x15), raster_width, raster_height
//  m_axis   out  tdata: dest_x, dest_y, clip_width, clip_height, skip_x, skip_y,
//                visible
//  cfg      in   index 3b, data 16b
//
// The pipe is the 25-stage divider (product stage beside its first stage),
// saturation and two clip stages; one beat per cycle unless the output stalls.
// The whole pipe advances only when the output register is free or being
// taken. Reset clears valid bits and the config registers to reset values.
// ----------------------------------------------------------------------------
module ndc_raster_place_and_clip_core #(
    parameter int COORD_BITS = ndc_rpc_pkg::COORD_BITS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // [14:0] anchor_x [29:15] anchor_y [44:30] lowleft_x [59:45] lowleft_y
    // [74:60] upright_x [89:75] upright_y [101:90] raster_width
    // [113:102] raster_height [119:114] zero
    input  logic [119:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // [15:0] dest_x [31:16] dest_y [43:32] clip_width [55:44] clip_height
    // [67:56] skip_x [79:68] skip_y [80] visible [87:81] zero
    output logic [87:0]  m_axis_tdata,
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [2:0]   i_cfg_index,
    input  logic [15:0]  i_cfg_data
);
    localparam int LAT = ndc_rpc_pkg::QUOT_BITS + 3;

    ndc_rpc_pkg::t_cfg r_cfg;
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mode     <= ndc_rpc_pkg::MODE_WINDOW;
            r_cfg.x_offset <= '0;
            r_cfg.y_offset <= '0;
            r_cfg.y_top    <= '0;
            r_cfg.divisor  <= 16'd1024;
            r_cfg.x_gain   <= 16'd32768;
            r_cfg.y_gain   <= 16'd32768;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                ndc_rpc_pkg::REG_MAP_MODE: r_cfg.mode     <= i_cfg_data[2:0];
                ndc_rpc_pkg::REG_X_OFFSET: r_cfg.x_offset <= i_cfg_data;
                ndc_rpc_pkg::REG_Y_OFFSET: r_cfg.y_offset <= i_cfg_data;
                ndc_rpc_pkg::REG_Y_TOP:    r_cfg.y_top    <= i_cfg_data;
                ndc_rpc_pkg::REG_DIVISOR:  r_cfg.divisor  <= i_cfg_data;
                ndc_rpc_pkg::REG_X_GAIN:   r_cfg.x_gain   <= i_cfg_data;
                ndc_rpc_pkg::REG_Y_GAIN:   r_cfg.y_gain   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    logic w_en;
    assign w_en = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = w_en;

    logic [LAT-1:0] r_vld;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_vld <= '0;
        else if (w_en) r_vld <= {r_vld[LAT-2:0], s_axis_tvalid};
    end
    assign m_axis_tvalid = r_vld[LAT-1];

    // raster size rides along with the mapping pipe
    localparam int MD = ndc_rpc_pkg::QUOT_BITS + 1;
    logic [23:0] r_sz [MD];
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sz[0] <= s_axis_tdata[113:90];
            for (int k = 1; k < MD; k++) r_sz[k] <= r_sz[k-1];
        end
    end

    logic signed [COORD_BITS-1:0] w_ax, w_ay, w_l, w_b, w_r, w_t;
    ndc_rpc_map #(.COORD_BITS(COORD_BITS)) u_map_a (.i_clk(i_clk), .i_en(w_en),
        .i_cfg(r_cfg), .i_nx(s_axis_tdata[14:0]), .i_ny(s_axis_tdata[29:15]),
        .o_dx(w_ax), .o_dy(w_ay));
    ndc_rpc_map #(.COORD_BITS(COORD_BITS)) u_map_l (.i_clk(i_clk), .i_en(w_en),
        .i_cfg(r_cfg), .i_nx(s_axis_tdata[44:30]), .i_ny(s_axis_tdata[59:45]),
        .o_dx(w_l), .o_dy(w_b));
    ndc_rpc_map #(.COORD_BITS(COORD_BITS)) u_map_u (.i_clk(i_clk), .i_en(w_en),
        .i_cfg(r_cfg), .i_nx(s_axis_tdata[74:60]), .i_ny(s_axis_tdata[89:75]),
        .o_dx(w_r), .o_dy(w_t));

    logic [15:0] w_dx, w_dy;
    logic [11:0] w_cw, w_ch, w_sx, w_sy;
    logic        w_vis;
    ndc_rpc_clip #(.COORD_BITS(COORD_BITS)) u_clip (.i_clk(i_clk), .i_en(w_en),
        .i_ax(w_ax), .i_ay(w_ay), .i_left(w_l), .i_bottom(w_b), .i_right(w_r),
        .i_top(w_t), .i_w(r_sz[MD-1][11:0]), .i_h(r_sz[MD-1][23:12]),
        .o_dx(w_dx), .o_dy(w_dy), .o_cw(w_cw), .o_ch(w_ch), .o_sx(w_sx),
        .o_sy(w_sy), .o_vis(w_vis));

    assign m_axis_tdata = {7'd0, w_vis, w_sy, w_sx, w_ch, w_cw, w_dy, w_dx};

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output beat changed under stall");
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready == (!m_axis_tvalid || m_axis_tready))
        else $error("input ready not tied to output slot");
    a_hidden: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tdata[80] |-> m_axis_tdata[79:0] == 80'd0)
        else $error("hidden result carries nonzero fields");
endmodule

### tb/tb_ndc_raster_place_and_clip_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ndc_raster_place_and_clip_core
// Drives placement requests through every mapping mode and register setting,
// predicts the clipped rectangle in a scoreboard and compares each result beat.
// ----------------------------------------------------------------------------

typedef struct {
    logic signed [15:0] dest_x;
    logic signed [15:0] dest_y;
    logic [11:0]        clip_w;
    logic [11:0]        clip_h;
    logic [11:0]        skip_x;
    logic [11:0]        skip_y;
    logic               visible;
} t_placement;

class placement_board;
    logic [2:0]   mode;
    longint       x_off, y_off, top, div, x_gain, y_gain;
    t_placement   pending[$];
    int           errors;

    function new();
        mode = ndc_rpc_pkg::MODE_WINDOW; x_off = 0; y_off = 0; top = 0;
        div = 1024; x_gain = 32768; y_gain = 32768; errors = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [15:0] v);
        case (idx)
            ndc_rpc_pkg::REG_MAP_MODE: mode   = v[2:0];
            ndc_rpc_pkg::REG_X_OFFSET: x_off  = longint'($signed(v));
            ndc_rpc_pkg::REG_Y_OFFSET: y_off  = longint'($signed(v));
            ndc_rpc_pkg::REG_Y_TOP:    top    = longint'($signed(v));
            ndc_rpc_pkg::REG_DIVISOR:  div    = longint'(v);
            ndc_rpc_pkg::REG_X_GAIN:   x_gain = longint'(v);
            ndc_rpc_pkg::REG_Y_GAIN:   y_gain = longint'(v);
            default: ;
        endcase
    endfunction

    function longint clamp16(longint v);
        if (v > 32767) return 32767;
        if (v < -32768) return -32768;
        return v;
    endfunction

    function void to_device(longint nx, longint ny, output longint dx, output longint dy);
        longint mx, my, d;
        d = (div == 0) ? 1 : div;
        case (mode)
            ndc_rpc_pkg::MODE_WINDOW: begin
                dx = ((nx * x_gain) >>> 15) + x_off;
                dy = top - ((ny * y_gain) >>> 15);
            end
            ndc_rpc_pkg::MODE_SQ_FIT_X: begin
                dx = nx >>> 5;
                dy = top - ((ny >>> 5) + y_off);
            end
            ndc_rpc_pkg::MODE_SQ_FIT_Y: begin
                dx = (nx >>> 5) + x_off;
                dy = top - (ny >>> 5);
            end
            ndc_rpc_pkg::MODE_NSQ_FIT_X: begin
                mx = (nx + (nx >>> 3)) >>> 5;
                my = (ny + (ny >>> 3)) >>> 5;
                dx = mx;
                dy = top - (my + y_off);
            end
            ndc_rpc_pkg::MODE_NSQ_FIT_Y: begin
                mx = (nx - (nx >>> 3)) >>> 5;
                my = (ny - (ny >>> 3)) >>> 5;
                dx = mx + x_off;
                dy = top - my;
            end
            default: begin
                dx = (nx * 1024) / d + x_off;
                dy = top - (ny * 1024) / d;
            end
        endcase
        dx = clamp16(dx);
        dy = clamp16(dy);
    endfunction

    function void note_request(logic [119:0] req);
        longint x, y, l, b, r, t, w, h, sx, sy;
        t_placement p;
        to_device(req[14:0], req[29:15], x, y);
        to_device(req[44:30], req[59:45], l, b);
        to_device(req[74:60], req[89:75], r, t);
        w = req[101:90];
        h = req[113:102];
        sx = 0; sy = 0;
        y = y - h + 1;
        p = '{default: 0};
        if (x < l) begin
            sx = l - x; w -= sx; x = l;
        end
        if (x + w - 1 > r) w = r - x + 1;
        if (w > 0) begin
            if (y < t) begin
                sy = t - y; h -= sy; y = t;
            end
            if (y + h - 1 > b) h = b - y + 1;
            if (h > 0) p = '{x[15:0], y[15:0], w[11:0], h[11:0], sx[11:0], sy[11:0], 1'b1};
        end
        pending.push_back(p);
    endfunction

    function void check_result(logic [87:0] d);
        t_placement e;
        if (pending.size() == 0) begin
            $error("unexpected result beat %h", d);
            errors++;
            return;
        end
        e = pending.pop_front();
        if (d[15:0] !== e.dest_x) begin
            $error("dest_x exp %0d got %0d", e.dest_x, $signed(d[15:0])); errors++;
        end
        if (d[31:16] !== e.dest_y) begin
            $error("dest_y exp %0d got %0d", e.dest_y, $signed(d[31:16])); errors++;
        end
        if (d[43:32] !== e.clip_w) begin
            $error("clip_width exp %0d got %0d", e.clip_w, d[43:32]); errors++;
        end
        if (d[55:44] !== e.clip_h) begin
            $error("clip_height exp %0d got %0d", e.clip_h, d[55:44]); errors++;
        end
        if (d[67:56] !== e.skip_x) begin
            $error("skip_x exp %0d got %0d", e.skip_x, d[67:56]); errors++;
        end
        if (d[79:68] !== e.skip_y) begin
            $error("skip_y exp %0d got %0d", e.skip_y, d[79:68]); errors++;
        end
        if (d[80] !== e.visible) begin
            $error("visible exp %0d got %0d", e.visible, d[80]); errors++;
        end
    endfunction
endclass

module tb_ndc_raster_place_and_clip_core;
    localparam int STALL_LIMIT = 20000;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [119:0] s_axis_tdata = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [87:0]  m_axis_tdata;
    logic         i_cfg_valid = 1'b0;
    logic         o_cfg_ready;
    logic [2:0]   i_cfg_index = '0;
    logic [15:0]  i_cfg_data = '0;

    placement_board board = new();
    bit  calm = 0;
    int  quiet_cycles = 0;

    ndc_raster_place_and_clip_core dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // output side: sample at rising edge, ready changes at falling edge
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) board.check_result(m_axis_tdata);
        if (i_rst_n && ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready)
                || (i_cfg_valid && o_cfg_ready)))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > STALL_LIMIT) begin
            $display("FAIL ndc_raster_place_and_clip_core");
            $finish;
        end
    end

    initial begin : sink_stall
        int n;
        @(negedge i_clk);
        forever begin
            if (calm || $urandom_range(0, 2) != 0) begin
                m_axis_tready <= 1'b1;
                @(negedge i_clk);
            end else begin
                n = $urandom_range(1, 10);
                m_axis_tready <= 1'b0;
                repeat (n) @(negedge i_clk);
            end
        end
    end

    task automatic write_cfg(logic [2:0] idx, logic [15:0] v);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= v;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        board.write_reg(idx, v);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        while (board.pending.size() != 0) @(negedge i_clk);
        repeat (40) @(negedge i_clk);
    endtask

    task automatic send_request(logic [14:0] ax, ay, lx, ly, ux, uy, logic [11:0] w, h);
        int n;
        if (!calm && $urandom_range(0, 5) == 0) begin
            n = $urandom_range(1, 10);
            s_axis_tvalid <= 1'b0;
            repeat (n) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {6'd0, h, w, uy, ux, ly, lx, ay, ax};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        board.note_request(s_axis_tdata);
        @(negedge i_clk);
    endtask

    task automatic idle_input();
        s_axis_tvalid <= 1'b0;
    endtask

    // well-placed viewport with random content, sometimes pure noise
    task automatic random_request();
        logic [14:0] lx, ly, ux, uy;
        if ($urandom_range(0, 4) == 0) begin
            send_request(15'($urandom), 15'($urandom), 15'($urandom), 15'($urandom),
                         15'($urandom), 15'($urandom), 12'($urandom), 12'($urandom));
        end else begin
            lx = 15'($urandom_range(0, 16383)); ux = lx + 15'($urandom_range(0, 16384));
            ly = 15'($urandom_range(0, 16383)); uy = ly + 15'($urandom_range(0, 16384));
            send_request(15'($urandom_range(0, 32767)), 15'($urandom_range(0, 32767)),
                         lx, ly, ux, uy,
                         ($urandom_range(0, 3) == 0) ? 12'($urandom) : 12'($urandom_range(0, 300)),
                         ($urandom_range(0, 3) == 0) ? 12'($urandom) : 12'($urandom_range(0, 300)));
        end
    endtask

    initial begin : stim
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: reset config, field extremes
        send_request(15'd0, 15'd0, 15'd0, 15'd0, 15'h7fff, 15'h7fff, 12'd0, 12'd0);
        send_request(15'h7fff, 15'h7fff, 15'd0, 15'd0, 15'h7fff, 15'h7fff, 12'hfff, 12'hfff);
        send_request(15'd100, 15'd20000, 15'd1000, 15'd1000, 15'd30000, 15'd30000, 12'd50, 12'd40);
        send_request(15'd500, 15'd500, 15'd1000, 15'd1000, 15'd30000, 15'd30000, 12'd900, 12'd900);
        send_request(15'd10000, 15'd10000, 15'd20000, 15'd20000, 15'd100, 15'd100, 12'd10, 12'd10);
        idle_input();
        drain();

        // extremes of each register; saturation in window mode, modes 6/7, divisor zero
        write_cfg(ndc_rpc_pkg::REG_X_GAIN, 16'hffff);
        write_cfg(ndc_rpc_pkg::REG_Y_GAIN, 16'hffff);
        write_cfg(ndc_rpc_pkg::REG_X_OFFSET, 16'h7fff);
        write_cfg(ndc_rpc_pkg::REG_Y_TOP, 16'h8000);
        write_cfg(ndc_rpc_pkg::REG_Y_OFFSET, 16'h8000);
        send_request(15'h7fff, 15'h7fff, 15'd0, 15'd0, 15'h7fff, 15'h7fff, 12'hfff, 12'd1);
        send_request(15'd1, 15'd1, 15'd0, 15'd0, 15'd2, 15'd2, 12'd3, 12'd3);
        idle_input();
        drain();
        for (int m = ndc_rpc_pkg::MODE_SQ_FIT_X; m <= 7; m++) begin
            write_cfg(ndc_rpc_pkg::REG_MAP_MODE, 3'(m));
            write_cfg(ndc_rpc_pkg::REG_X_OFFSET, (m % 2) ? 16'h8000 : 16'd0);
            write_cfg(ndc_rpc_pkg::REG_Y_OFFSET, (m % 2) ? 16'h7fff : 16'd5);
            write_cfg(ndc_rpc_pkg::REG_Y_TOP, (m > 4) ? 16'h7fff : 16'd1000);
            write_cfg(ndc_rpc_pkg::REG_DIVISOR,
                      (m == 6) ? 16'd0 : ((m == 7) ? 16'd1 : 16'hffff));
            send_request(15'd0, 15'd0, 15'd0, 15'd0, 15'h7fff, 15'h7fff, 12'd20, 12'd20);
            send_request(15'h7fff, 15'h7fff, 15'd0, 15'd0, 15'h7fff, 15'h7fff, 12'hfff, 12'hfff);
            send_request(15'd3000, 15'd3000, 15'd1000, 15'd1000, 15'd9000, 15'd9000,
                         12'd500, 12'd500);
            idle_input();
            drain();
        end

        // random phases over random register settings
        for (int ph = 0; ph < 10; ph++) begin
            write_cfg(ndc_rpc_pkg::REG_MAP_MODE, 3'($urandom_range(0, 7)));
            write_cfg(ndc_rpc_pkg::REG_X_OFFSET,
                      (ph == 0) ? 16'd0 : 16'($urandom_range(0, 65535)));
            write_cfg(ndc_rpc_pkg::REG_Y_OFFSET, 16'($urandom_range(0, 400)) - 16'd200);
            write_cfg(ndc_rpc_pkg::REG_Y_TOP, 16'($urandom_range(0, 2000)));
            write_cfg(ndc_rpc_pkg::REG_DIVISOR, 16'($urandom_range(0, 4096)));
            write_cfg(ndc_rpc_pkg::REG_X_GAIN, 16'($urandom));
            write_cfg(ndc_rpc_pkg::REG_Y_GAIN, (ph == 3) ? 16'd0 : 16'($urandom));
            if (ph == 8) calm = 1;
            for (int k = 0; k < 50; k++) random_request();
            idle_input();
            drain();
        end

        if (board.errors == 0 && board.pending.size() == 0)
            $display("PASS ndc_raster_place_and_clip_core");
        else
            $display("FAIL ndc_raster_place_and_clip_core");
        $finish;
    end
endmodule
